/* rtl/hps_pkg.sv */
// ---------------------------------------------------------------------------
// hps_pkg: shared types and constants of the host power supervisor
// Command codes, register indexes, timing constants and the host wake and
// reset helpers that the execution stage applies.
// ---------------------------------------------------------------------------
`default_nettype none
package hps_pkg;

    localparam int unsigned TASK_PERIOD_MS      = 900;
    localparam int unsigned HOST_IDLE_MS        = 15000;
    localparam int unsigned TURN_ON_DELAY_MS    = 100;
    localparam int unsigned WAKE_GUARD_MS       = 15000;
    localparam int unsigned WAKE_REPEAT_MS      = 30000;
    localparam int unsigned BUTTON_HOST_IDLE_MS = 11000;
    localparam int unsigned SOC_HIGH            = 500;
    localparam int unsigned SOC_LOW             = 150;
    localparam int unsigned SCHED_MAX           = 250;
    localparam int unsigned SCHED_CANCEL        = 255;
    localparam int unsigned OFF_INACTIVE        = 255;
    localparam int unsigned WAKE_PCT_MAX        = 100;
    localparam int unsigned WAKE_PCT_OFF        = 127;
    localparam int unsigned PCT_TO_TENTHS       = 10;
    localparam int unsigned MS_PER_MIN          = 60000;
    localparam int unsigned TASK_MS_MAX         = 1023;
    localparam int unsigned TURN_ON_MS_MAX      = 127;
    localparam int unsigned QUEUE_DEPTH         = 2;

    // Command codes; unused codes are classified as a status read
    typedef enum logic [3:0] {
        CMD_TICK      = 4'd0,
        CMD_ON_BTN    = 4'd1,
        CMD_OFF_BTN   = 4'd2,
        CMD_RESET_BTN = 4'd3,
        CMD_HOST_CMD  = 4'd4,
        CMD_HOST_POLL = 4'd5,
        CMD_RTC_WAKE  = 4'd6,
        CMD_SCHED_OFF = 4'd7,
        CMD_SET_WAKE  = 4'd8,
        CMD_READ      = 4'd9
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [7:0] {
        CFG_RUN_PIN   = 8'd0,
        CFG_WDOG_MIN  = 8'd1,
        CFG_LED_RED   = 8'd2,
        CFG_LED_GREEN = 8'd3,
        CFG_LED_BLUE  = 8'd4
    } t_cfg_idx;

    // Classified item passed from the front end to the execution stage
    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  arg;
        logic        sched_start;
        logic        sched_cancel;
        logic [6:0]  wake_pct;
        logic [9:0]  soc;
        logic        inp;
        logic        batp;
        logic        io5v;
        logic        chg;
        logic        done;
        logic        lowp;
    } t_item;

    // Result transaction
    typedef struct packed {
        logic        boost_enable;
        logic        run_pulse;
        logic        led_update;
        logic [7:0]  led_r;
        logic [7:0]  led_g;
        logic [7:0]  led_b;
        logic        action_ok;
        logic [7:0]  off_countdown;
        logic [6:0]  wake_charge_read;
        logic        watchdog_fired;
        logic        off_button_used;
    } t_result;

    // Host power state touched by a wake or reset
    typedef struct packed {
        logic        boost;
        logic        pending;
        logic [6:0]  ton_ms;
        logic [31:0] wake_idle;
        logic        pulse;
        logic        ok;
    } t_host;

    // Reset the host by RUN pulse, power-on or power cycle
    function automatic t_host f_reset_host(t_host h, logic io5v, logic run_pin);
        t_host r;
        r    = h;
        r.ok = 1'b0;
        if ((h.boost || io5v) && run_pin) begin
            r.boost     = 1'b1;
            r.pulse     = 1'b1;
            r.wake_idle = '0;
            r.ok        = 1'b1;
        end else if (!io5v) begin
            if (h.boost) begin
                r.boost   = 1'b0;
                r.pending = 1'b1;
                r.ton_ms  = '0;
            end else begin
                r.boost = 1'b1;
            end
            r.wake_idle = '0;
            r.ok        = 1'b1;
        end
        return r;
    endfunction

    // Wake the host, resetting it only when it looks dead or unpowered
    function automatic t_host f_wake_host(t_host h, logic io5v, logic run_pin,
                                          logic [31:0] host_idle);
        t_host r;
        r = h;
        if (host_idle > 32'(HOST_IDLE_MS) || (!h.boost && !io5v)) begin
            r = f_reset_host(h, io5v, run_pin);
        end else begin
            r.ok = 1'b1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/host_power_supervisor.sv */
// ---------------------------------------------------------------------------
// host_power_supervisor: 5 V boost supply supervisor for a host
// Front end, decoupling queue and execution stage for tick and event items.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one item per transaction:
//   a 1 ms tick or an event with charger status. Output channel
//   (o_out_valid / i_out_ready) returns exactly one result per item, in order.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes a register by
//   index: 0 RUN pin installed, 1 watchdog minutes, 2..4 LED intensities.
//   o_cfg_ready is always high; write only while no item is in flight.
// Pipeline and throughput:
//   An accepted item is held in the front register, pushed from there into
//   the queue and popped into the execution stage's output register. One
//   item per cycle is sustained while the receiver keeps i_out_ready high;
//   the execution stage updates all state for an item when it pops it.
// Reset:
//   Synchronous, active low. Timers and flags clear, boost is off, the wake
//   threshold is disabled and all configuration registers read zero.
// Stalls:
//   When the receiver holds i_out_ready low the result register holds, the
//   two-entry queue fills and then the front stage drops o_in_ready.
// ---------------------------------------------------------------------------
`default_nettype none
module host_power_supervisor (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [3:0]    i_cmd,
    input  wire logic [7:0]    i_arg,
    input  wire logic [9:0]    i_battery_soc,
    input  wire logic          i_input_present,
    input  wire logic          i_battery_present,
    input  wire logic          i_io5v_present,
    input  wire logic          i_charging,
    input  wire logic          i_charge_done,
    input  wire logic          i_low_power,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic               o_boost_enable,
    output logic               o_run_pulse,
    output logic               o_led_update,
    output logic [7:0]         o_led_r,
    output logic [7:0]         o_led_g,
    output logic [7:0]         o_led_b,
    output logic               o_action_ok,
    output logic [7:0]         o_off_countdown,
    output logic [6:0]         o_wake_charge_read,
    output logic               o_watchdog_fired,
    output logic               o_off_button_used,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [7:0]    i_cfg_index,
    input  wire logic [15:0]   i_cfg_data
);

    logic             w_push;
    logic             w_q_ready;
    logic             w_q_valid;
    logic             w_pop;
    hps_pkg::t_item   w_front_item;
    hps_pkg::t_item   w_head_item;
    hps_pkg::t_result w_result;

    assign o_cfg_ready = 1'b1;

    // Accept and classify
    hps_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_arg             (i_arg),
        .i_battery_soc     (i_battery_soc),
        .i_input_present   (i_input_present),
        .i_battery_present (i_battery_present),
        .i_io5v_present    (i_io5v_present),
        .i_charging        (i_charging),
        .i_charge_done     (i_charge_done),
        .i_low_power       (i_low_power),
        .o_push            (w_push),
        .o_item            (w_front_item),
        .i_q_ready         (w_q_ready)
    );

    // Decouple front and execution
    hps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_item  (w_head_item),
        .i_pop   (w_pop)
    );

    // Execute and register results
    hps_exec u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_item      (w_head_item),
        .o_pop       (w_pop),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .o_result    (w_result),
        .i_out_ready (i_out_ready)
    );

    assign o_boost_enable     = w_result.boost_enable;
    assign o_run_pulse        = w_result.run_pulse;
    assign o_led_update       = w_result.led_update;
    assign o_led_r            = w_result.led_r;
    assign o_led_g            = w_result.led_g;
    assign o_led_b            = w_result.led_b;
    assign o_action_ok        = w_result.action_ok;
    assign o_off_countdown    = w_result.off_countdown;
    assign o_wake_charge_read = w_result.wake_charge_read;
    assign o_watchdog_fired   = w_result.watchdog_fired;
    assign o_off_button_used  = w_result.off_button_used;

endmodule
`default_nettype wire

/* rtl/hps_front.sv */
// ---------------------------------------------------------------------------
// hps_front: input stage
// Registers each input transaction and classifies its command and argument.
// ---------------------------------------------------------------------------
`default_nettype none
module hps_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [3:0]    i_cmd,
    input  wire logic [7:0]    i_arg,
    input  wire logic [9:0]    i_battery_soc,
    input  wire logic          i_input_present,
    input  wire logic          i_battery_present,
    input  wire logic          i_io5v_present,
    input  wire logic          i_charging,
    input  wire logic          i_charge_done,
    input  wire logic          i_low_power,
    output logic               o_push,
    output hps_pkg::t_item     o_item,
    input  wire logic          i_q_ready
);

    logic           r_valid;
    hps_pkg::t_item r_item;
    hps_pkg::t_item n_item;

    // Classify command and argument
    always_comb begin
        n_item = '0;
        if (i_cmd > 4'(hps_pkg::CMD_READ)) begin
            n_item.cmd = hps_pkg::CMD_READ;
        end else begin
            n_item.cmd = hps_pkg::t_cmd'(i_cmd);
        end
        n_item.arg          = i_arg;
        n_item.sched_start  = (i_arg <= 8'(hps_pkg::SCHED_MAX));
        n_item.sched_cancel = (i_arg == 8'(hps_pkg::SCHED_CANCEL));
        n_item.wake_pct     = (i_arg[6:0] <= 7'(hps_pkg::WAKE_PCT_MAX)) ?
                              i_arg[6:0] : 7'(hps_pkg::WAKE_PCT_OFF);
        n_item.soc          = i_battery_soc;
        n_item.inp          = i_input_present;
        n_item.batp         = i_battery_present;
        n_item.io5v         = i_io5v_present;
        n_item.chg          = i_charging;
        n_item.done         = i_charge_done;
        n_item.lowp         = i_low_power;
    end

    assign o_in_ready = !r_valid || i_q_ready;
    assign o_push     = r_valid;
    assign o_item     = r_item;

    // Hold the classified transaction until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

/* rtl/hps_queue.sv */
// ---------------------------------------------------------------------------
// hps_queue: decoupling queue
// Short FIFO of classified transactions between front end and execution.
// ---------------------------------------------------------------------------
`default_nettype none
module hps_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire hps_pkg::t_item i_item,
    output logic               o_ready,
    output logic               o_valid,
    output hps_pkg::t_item     o_item,
    input  wire logic          i_pop
);

    localparam int unsigned PW = $clog2(hps_pkg::QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(hps_pkg::QUEUE_DEPTH + 1);

    hps_pkg::t_item r_mem [hps_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           w_do_push;
    logic           w_do_pop;

    assign o_ready   = (r_count != CW'(hps_pkg::QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_item    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && o_ready;
    assign w_do_pop  = i_pop && o_valid;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(hps_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(hps_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_do_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store the incoming transaction
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(hps_pkg::QUEUE_DEPTH))
        else $error("queue occupancy out of range");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_do_push && !w_do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue occupancy lost a push");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CW'(hps_pkg::QUEUE_DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with occupancy");

endmodule
`default_nettype wire

/* rtl/hps_exec.sv */
// ---------------------------------------------------------------------------
// hps_exec: execution stage
// Holds the supervisor state and configuration, applies one transaction a
// cycle while the result register is free or being taken, and registers the result.
// ---------------------------------------------------------------------------
`default_nettype none
module hps_exec (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire hps_pkg::t_item i_item,
    output logic               o_pop,
    input  wire logic          i_cfg_valid,
    input  wire logic [7:0]    i_cfg_index,
    input  wire logic [15:0]   i_cfg_data,
    output logic               o_out_valid,
    output hps_pkg::t_result   o_result,
    input  wire logic          i_out_ready
);

    // Configuration
    logic        r_run_pin;
    logic [15:0] r_wdog_min;
    logic [31:0] r_period;
    logic [7:0]  r_led_red, r_led_green, r_led_blue;

    // Supervisor state
    logic [31:0] r_host_idle, n_host_idle;
    logic [31:0] r_wake_idle;
    logic [9:0]  r_task_ms, n_task_ms;
    logic        r_pending;
    logic [6:0]  r_ton_ms;
    logic [17:0] r_off_ms, n_off_ms;
    logic        r_off_active, n_off_active;
    logic [31:0] r_deadline, n_deadline;
    logic        r_wdog_flag, n_wdog_flag;
    logic        r_rtc, n_rtc;
    logic        r_off_btn, n_off_btn;
    logic [6:0]  r_wake_pct, n_wake_pct;
    logic [7:0]  r_blink, n_blink;
    logic        r_boost;
    logic [23:0] r_colour, n_colour;

    logic              r_out_valid;
    hps_pkg::t_result  r_out, n_out;

    hps_pkg::t_host h;
    logic [10:0]    w_thresh;
    logic           w_thresh_on;
    logic [7:0]     w_r, w_g;
    logic           w_led_upd, w_ok;
    logic [32:0]    w_dl_sum;
    logic [31:0]    w_cfg_period;

    assign o_pop       = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    assign w_thresh     = 11'(r_wake_pct) * 11'(hps_pkg::PCT_TO_TENTHS);
    assign w_thresh_on  = (r_wake_pct != 7'(hps_pkg::WAKE_PCT_OFF));
    assign w_dl_sum     = {1'b0, r_deadline} + {1'b0, r_period};
    assign w_cfg_period = 32'(i_cfg_data) * 32'(hps_pkg::MS_PER_MIN);

    // Apply one transaction to the state
    always_comb begin
        n_host_idle  = r_host_idle;
        n_task_ms    = r_task_ms;
        n_off_ms     = r_off_ms;
        n_off_active = r_off_active;
        n_deadline   = r_deadline;
        n_wdog_flag  = r_wdog_flag;
        n_rtc        = r_rtc;
        n_off_btn    = r_off_btn;
        n_wake_pct   = r_wake_pct;
        n_blink      = r_blink;
        n_colour     = r_colour;
        h.boost      = r_boost;
        h.pending    = r_pending;
        h.ton_ms     = r_ton_ms;
        h.wake_idle  = r_wake_idle;
        h.pulse      = 1'b0;
        h.ok         = 1'b0;
        w_r          = '0;
        w_g          = '0;
        w_led_upd    = 1'b0;
        w_ok         = 1'b0;

        case (i_item.cmd)
            hps_pkg::CMD_TICK: begin
                if (n_host_idle != '1) n_host_idle = n_host_idle + 32'd1;
                if (h.wake_idle != '1) h.wake_idle = h.wake_idle + 32'd1;
                if (n_task_ms < 10'(hps_pkg::TASK_MS_MAX)) n_task_ms = n_task_ms + 10'd1;
                if (h.ton_ms < 7'(hps_pkg::TURN_ON_MS_MAX)) h.ton_ms = h.ton_ms + 7'd1;
                if (n_task_ms >= 10'(hps_pkg::TASK_PERIOD_MS)) begin
                    n_task_ms = '0;
                    // recolour the charge LED
                    if (i_item.soc > 10'(hps_pkg::SOC_HIGH)) begin
                        w_r = '0;
                        w_g = r_led_green;
                    end else if (i_item.soc > 10'(hps_pkg::SOC_LOW)) begin
                        w_r = r_led_red;
                        w_g = r_led_green;
                    end else begin
                        w_r = r_led_red;
                        w_g = '0;
                    end
                    if (i_item.chg) begin
                        n_blink = (r_blink != '0) ? 8'd0 : r_led_blue;
                    end else if (i_item.done) begin
                        n_blink = r_led_blue;
                    end else begin
                        n_blink = '0;
                    end
                    if (i_item.lowp) begin
                        w_r = w_r >> 2;
                        w_g = w_g >> 2;
                    end
                    n_colour  = {w_r, w_g, n_blink};
                    w_led_upd = 1'b1;
                    // wake on charge level or RTC alarm
                    if (((w_thresh_on && 11'(i_item.soc) >= w_thresh && i_item.inp &&
                          i_item.batp) || r_rtc) &&
                        n_host_idle > 32'(hps_pkg::HOST_IDLE_MS) &&
                        h.wake_idle > 32'(hps_pkg::WAKE_REPEAT_MS)) begin
                        h = hps_pkg::f_wake_host(h, i_item.io5v, r_run_pin, n_host_idle);
                        if (h.ok) begin
                            w_ok         = 1'b1;
                            n_wake_pct   = 7'(hps_pkg::WAKE_PCT_OFF);
                            n_rtc        = 1'b0;
                            n_off_active = 1'b0;
                            n_off_ms     = '0;
                        end
                    end
                    // host watchdog
                    if (r_wdog_min != '0 && n_host_idle > r_deadline) begin
                        h = hps_pkg::f_wake_host(h, i_item.io5v, r_run_pin, n_host_idle);
                        if (h.ok) begin
                            w_ok         = 1'b1;
                            n_wake_pct   = 7'(hps_pkg::WAKE_PCT_OFF);
                            n_rtc        = 1'b0;
                            n_off_active = 1'b0;
                            n_off_ms     = '0;
                            n_wdog_flag  = 1'b1;
                        end
                        n_deadline = w_dl_sum[32] ? '1 : w_dl_sum[31:0];
                    end
                end
                // delayed turn-on
                if (h.pending && h.ton_ms >= 7'(hps_pkg::TURN_ON_DELAY_MS)) begin
                    h.boost   = 1'b1;
                    h.pending = 1'b0;
                end
                // scheduled power-off countdown
                if (n_off_active) begin
                    if (n_off_ms != '0) n_off_ms = n_off_ms - 18'd1;
                    if (n_off_ms == '0) begin
                        h.boost      = 1'b0;
                        n_off_active = 1'b0;
                    end
                end
            end
            hps_pkg::CMD_ON_BTN: begin
                if ((!h.boost && !i_item.io5v) ||
                    (h.wake_idle > 32'(hps_pkg::WAKE_GUARD_MS) &&
                     n_host_idle > 32'(hps_pkg::BUTTON_HOST_IDLE_MS))) begin
                    h = hps_pkg::f_wake_host(h, i_item.io5v, r_run_pin, n_host_idle);
                    if (h.ok) begin
                        w_ok         = 1'b1;
                        n_wake_pct   = 7'(hps_pkg::WAKE_PCT_OFF);
                        n_rtc        = 1'b0;
                        n_off_active = 1'b0;
                        n_off_ms     = '0;
                    end
                end
            end
            hps_pkg::CMD_OFF_BTN: begin
                if (h.boost && !i_item.io5v) begin
                    h.boost   = 1'b0;
                    n_off_btn = 1'b1;
                end
            end
            hps_pkg::CMD_RESET_BTN: begin
                h = hps_pkg::f_reset_host(h, i_item.io5v, r_run_pin);
                if (h.ok) begin
                    w_ok         = 1'b1;
                    n_wake_pct   = 7'(hps_pkg::WAKE_PCT_OFF);
                    n_rtc        = 1'b0;
                    n_off_active = 1'b0;
                    n_off_ms     = '0;
                end
            end
            hps_pkg::CMD_HOST_CMD: begin
                n_host_idle = '0;
            end
            hps_pkg::CMD_HOST_POLL: begin
                n_rtc      = 1'b0;
                n_deadline = r_period;
            end
            hps_pkg::CMD_RTC_WAKE: begin
                n_rtc = 1'b1;
            end
            hps_pkg::CMD_SCHED_OFF: begin
                if (i_item.sched_start) begin
                    n_off_ms     = {i_item.arg, 10'd0};
                    n_off_active = 1'b1;
                end else if (i_item.sched_cancel) begin
                    n_off_ms     = '0;
                    n_off_active = 1'b0;
                end
            end
            hps_pkg::CMD_SET_WAKE: begin
                n_wake_pct = i_item.wake_pct;
            end
            default: begin
            end
        endcase
    end

    // Assemble the result transaction
    always_comb begin
        n_out.boost_enable     = h.boost;
        n_out.run_pulse        = h.pulse;
        n_out.led_update       = w_led_upd;
        n_out.led_r            = n_colour[23:16];
        n_out.led_g            = n_colour[15:8];
        n_out.led_b            = n_colour[7:0];
        n_out.action_ok        = w_ok;
        n_out.off_countdown    = n_off_active ? n_off_ms[17:10] : 8'(hps_pkg::OFF_INACTIVE);
        n_out.wake_charge_read = n_wake_pct;
        n_out.watchdog_fired   = n_wdog_flag;
        n_out.off_button_used  = n_off_btn;
    end

    // Update state on a popped transaction, registers on a configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_pin    <= 1'b0;
            r_wdog_min   <= '0;
            r_period     <= '0;
            r_led_red    <= '0;
            r_led_green  <= '0;
            r_led_blue   <= '0;
            r_host_idle  <= '0;
            r_wake_idle  <= '0;
            r_task_ms    <= '0;
            r_pending    <= 1'b0;
            r_ton_ms     <= '0;
            r_off_ms     <= '0;
            r_off_active <= 1'b0;
            r_deadline   <= '0;
            r_wdog_flag  <= 1'b0;
            r_rtc        <= 1'b0;
            r_off_btn    <= 1'b0;
            r_wake_pct   <= 7'(hps_pkg::WAKE_PCT_OFF);
            r_blink      <= '0;
            r_boost      <= 1'b0;
            r_colour     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_host_idle  <= n_host_idle;
                r_wake_idle  <= h.wake_idle;
                r_task_ms    <= n_task_ms;
                r_pending    <= h.pending;
                r_ton_ms     <= h.ton_ms;
                r_off_ms     <= n_off_ms;
                r_off_active <= n_off_active;
                r_deadline   <= n_deadline;
                r_wdog_flag  <= n_wdog_flag;
                r_rtc        <= n_rtc;
                r_off_btn    <= n_off_btn;
                r_wake_pct   <= n_wake_pct;
                r_blink      <= n_blink;
                r_boost      <= h.boost;
                r_colour     <= n_colour;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    hps_pkg::CFG_RUN_PIN:   r_run_pin   <= i_cfg_data[0];
                    hps_pkg::CFG_WDOG_MIN: begin
                        r_wdog_min <= i_cfg_data;
                        r_period   <= w_cfg_period;
                        r_deadline <= w_cfg_period;
                    end
                    hps_pkg::CFG_LED_RED:   r_led_red   <= i_cfg_data[7:0];
                    hps_pkg::CFG_LED_GREEN: r_led_green <= i_cfg_data[7:0];
                    hps_pkg::CFG_LED_BLUE:  r_led_blue  <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Hold the result payload while it waits
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    a_off_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_off_active |-> (r_off_ms == '0))
        else $error("off countdown left time while inactive");
    a_task_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_task_ms < 10'(hps_pkg::TASK_PERIOD_MS))
        else $error("task timer passed its period");
    a_wake_pct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wake_pct <= 7'(hps_pkg::WAKE_PCT_MAX)) || (r_wake_pct == 7'(hps_pkg::WAKE_PCT_OFF)))
        else $error("wake threshold holds an invalid percent");
    a_period_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wdog_min == '0) |-> (r_period == '0))
        else $error("watchdog period out of step with minutes");

endmodule
`default_nettype wire

/* bench/tb.sv */
// ---------------------------------------------------------------------------
// tb: self-checking bench for host_power_supervisor
// Drives tick and event transactions with random gaps and receiver stalls,
// predicts every result with a cycle-free behavioral model of the supervisor
// and compares each result field by field, in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb;

    localparam int unsigned IDLE_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [3:0]  i_cmd;
    logic [7:0]  i_arg;
    logic [9:0]  i_battery_soc;
    logic        i_input_present, i_battery_present, i_io5v_present;
    logic        i_charging, i_charge_done, i_low_power;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_boost_enable, o_run_pulse, o_led_update;
    logic [7:0]  o_led_r, o_led_g, o_led_b;
    logic        o_action_ok;
    logic [7:0]  o_off_countdown;
    logic [6:0]  o_wake_charge_read;
    logic        o_watchdog_fired, o_off_button_used;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    host_power_supervisor dut (.*);

    always #5 i_clk = ~i_clk;

    // Predicted supervisor state and configuration
    logic        run_pin;
    logic [15:0] wd_minutes;
    logic [7:0]  int_red, int_green, int_blue;
    logic [31:0] host_idle, wake_idle, wd_deadline;
    int unsigned task_cnt, ton_cnt, off_left, wake_thresh;
    logic        ton_pending, off_running, wd_flag, rtc_armed, offb_flag;
    logic        boost, pulse;
    logic [7:0]  blink;
    logic [23:0] led_rgb;

    hps_pkg::t_result expected_results[$];
    int unsigned errors = 0;
    int unsigned idle_cycles = 0;
    int unsigned stall_left = 0;
    bit          calm = 1'b0;

    // Mostly short gaps, a few long ones, none while calm
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic logic [31:0] wd_period();
        return 32'(wd_minutes) * 32'(hps_pkg::MS_PER_MIN);
    endfunction

    task automatic host_reset(input logic io5v, output bit ok);
        ok = 1'b0;
        if ((boost || io5v) && run_pin) begin
            boost = 1'b1;
            pulse = 1'b1;
            wake_idle = '0;
            ok = 1'b1;
        end else if (!io5v) begin
            if (boost) begin
                boost = 1'b0;
                ton_pending = 1'b1;
                ton_cnt = 0;
            end else begin
                boost = 1'b1;
            end
            wake_idle = '0;
            ok = 1'b1;
        end
    endtask

    task automatic host_wake(input logic io5v, output bit ok);
        if (host_idle > 32'(hps_pkg::HOST_IDLE_MS) || (!boost && !io5v)) host_reset(io5v, ok);
        else ok = 1'b1;
    endtask

    function automatic void drop_wake_sources();
        wake_thresh = 2047;
        rtc_armed = 1'b0;
        off_running = 1'b0;
        off_left = 0;
    endfunction

    function automatic void model_reset();
        run_pin = 0; wd_minutes = 0; int_red = 0; int_green = 0; int_blue = 0;
        host_idle = 0; wake_idle = 0; wd_deadline = 0; task_cnt = 0; ton_cnt = 0;
        off_left = 0; wake_thresh = 2047; ton_pending = 0; off_running = 0;
        wd_flag = 0; rtc_armed = 0; offb_flag = 0; boost = 0; pulse = 0;
        blink = 0; led_rgb = 0;
    endfunction

    function automatic void model_config(hps_pkg::t_cfg_idx idx, logic [15:0] data);
        case (idx)
            hps_pkg::CFG_RUN_PIN:   run_pin = data[0];
            hps_pkg::CFG_WDOG_MIN: begin
                wd_minutes = data;
                wd_deadline = wd_period();
            end
            hps_pkg::CFG_LED_RED:   int_red = data[7:0];
            hps_pkg::CFG_LED_GREEN: int_green = data[7:0];
            hps_pkg::CFG_LED_BLUE:  int_blue = data[7:0];
            default: ;
        endcase
    endfunction

    // Compute the result of one accepted transaction and advance the state
    task automatic predict_result(input logic [3:0] cmd, input logic [7:0] arg,
                                  input logic [9:0] soc, input logic [5:0] st,
                                  output hps_pkg::t_result res);
        logic inp, batp, io5v, chg, done, lowp;
        logic [7:0] r, g;
        logic [32:0] sum;
        bit ok, w;
        inp = st[5]; batp = st[4]; io5v = st[3]; chg = st[2]; done = st[1]; lowp = st[0];
        ok = 1'b0;
        res = '0;
        pulse = 1'b0;
        case (cmd)
            hps_pkg::CMD_TICK: begin
                host_idle = sat_inc(host_idle);
                wake_idle = sat_inc(wake_idle);
                if (task_cnt < hps_pkg::TASK_MS_MAX) task_cnt++;
                if (ton_cnt < hps_pkg::TURN_ON_MS_MAX) ton_cnt++;
                if (task_cnt >= hps_pkg::TASK_PERIOD_MS) begin
                    task_cnt = 0;
                    if (soc > hps_pkg::SOC_HIGH) begin
                        r = 0; g = int_green;
                    end else if (soc > hps_pkg::SOC_LOW) begin
                        r = int_red; g = int_green;
                    end else begin
                        r = int_red; g = 0;
                    end
                    if (chg) blink = (blink != 0) ? 8'd0 : int_blue;
                    else if (done) blink = int_blue;
                    else blink = 0;
                    if (lowp) begin
                        r = r >> 2; g = g >> 2;
                    end
                    led_rgb = {r, g, blink};
                    res.led_update = 1'b1;
                    // Wake on charge level or RTC once the host looks idle
                    if (((int'(soc) >= wake_thresh && inp && batp) || rtc_armed)
                        && host_idle > 32'(hps_pkg::HOST_IDLE_MS)
                        && wake_idle > 32'(hps_pkg::WAKE_REPEAT_MS)) begin
                        host_wake(io5v, w);
                        if (w) begin
                            ok = 1'b1;
                            drop_wake_sources();
                        end
                    end
                    // Host watchdog, deadline saturates
                    if (wd_minutes != 0 && host_idle > wd_deadline) begin
                        host_wake(io5v, w);
                        if (w) begin
                            ok = 1'b1;
                            drop_wake_sources();
                            wd_flag = 1'b1;
                        end
                        sum = {1'b0, wd_deadline} + {1'b0, wd_period()};
                        wd_deadline = sum[32] ? '1 : sum[31:0];
                    end
                end
                if (ton_pending && ton_cnt >= hps_pkg::TURN_ON_DELAY_MS) begin
                    boost = 1'b1;
                    ton_pending = 1'b0;
                end
                if (off_running) begin
                    if (off_left > 0) off_left--;
                    if (off_left == 0) begin
                        boost = 1'b0;
                        off_running = 1'b0;
                    end
                end
            end
            hps_pkg::CMD_ON_BTN: begin
                if ((!boost && !io5v) || (wake_idle > 32'(hps_pkg::WAKE_GUARD_MS)
                    && host_idle > 32'(hps_pkg::BUTTON_HOST_IDLE_MS))) begin
                    host_wake(io5v, w);
                    if (w) begin
                        ok = 1'b1;
                        drop_wake_sources();
                    end
                end
            end
            hps_pkg::CMD_OFF_BTN: begin
                if (boost && !io5v) begin
                    boost = 1'b0;
                    offb_flag = 1'b1;
                end
            end
            hps_pkg::CMD_RESET_BTN: begin
                host_reset(io5v, w);
                if (w) begin
                    ok = 1'b1;
                    drop_wake_sources();
                end
            end
            hps_pkg::CMD_HOST_CMD:  host_idle = '0;
            hps_pkg::CMD_HOST_POLL: begin
                rtc_armed = 1'b0;
                wd_deadline = wd_period();
            end
            hps_pkg::CMD_RTC_WAKE:  rtc_armed = 1'b1;
            hps_pkg::CMD_SCHED_OFF: begin
                if (arg <= hps_pkg::SCHED_MAX) begin
                    off_left = int'(arg) * 1024;
                    off_running = 1'b1;
                end else if (arg == hps_pkg::SCHED_CANCEL) begin
                    off_left = 0;
                    off_running = 1'b0;
                end
            end
            hps_pkg::CMD_SET_WAKE: begin
                wake_thresh = (arg[6:0] <= hps_pkg::WAKE_PCT_MAX)
                              ? int'(arg[6:0]) * hps_pkg::PCT_TO_TENTHS : 2047;
            end
            default: ;
        endcase
        res.boost_enable = boost;
        res.run_pulse = pulse;
        {res.led_r, res.led_g, res.led_b} = led_rgb;
        res.action_ok = ok;
        res.off_countdown = off_running ? 8'(off_left >> 10) : 8'(hps_pkg::OFF_INACTIVE);
        res.wake_charge_read = (wake_thresh <= 1000) ? 7'(wake_thresh / 10)
                                                     : 7'(hps_pkg::WAKE_PCT_OFF);
        res.watchdog_fired = wd_flag;
        res.off_button_used = offb_flag;
    endtask

    // Send one transaction; returns at the edge where it was accepted
    task automatic send_item(input logic [3:0] cmd, input logic [7:0] arg,
                             input logic [9:0] soc, input logic [5:0] st);
        int unsigned gap;
        hps_pkg::t_result res;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_arg <= arg;
        i_battery_soc <= soc;
        {i_input_present, i_battery_present, i_io5v_present,
         i_charging, i_charge_done, i_low_power} <= st;
        do @(posedge i_clk); while (!o_in_ready);
        predict_result(cmd, arg, soc, st, res);
        expected_results.push_back(res);
    endtask

    task automatic send_ticks(input int unsigned n, input logic [9:0] soc,
                              input logic [5:0] st);
        repeat (n) send_item(hps_pkg::CMD_TICK, 8'd0, soc, st);
    endtask

    // Hold off until every result is back, then let the pipeline settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input hps_pkg::t_cfg_idx idx, input logic [15:0] data);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        model_config(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $realtime, name, exp, act);
        end
    endfunction

    // Compare each result transaction, stall the receiver at random, watch for hangs
    always @(posedge i_clk) begin
        hps_pkg::t_result exp;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result transaction", $realtime);
                end else begin
                    exp = expected_results.pop_front();
                    check_field("boost_enable", exp.boost_enable, o_boost_enable);
                    check_field("run_pulse", exp.run_pulse, o_run_pulse);
                    check_field("led_update", exp.led_update, o_led_update);
                    check_field("led_r", exp.led_r, o_led_r);
                    check_field("led_g", exp.led_g, o_led_g);
                    check_field("led_b", exp.led_b, o_led_b);
                    check_field("action_ok", exp.action_ok, o_action_ok);
                    check_field("off_countdown", exp.off_countdown, o_off_countdown);
                    check_field("wake_charge_read", exp.wake_charge_read, o_wake_charge_read);
                    check_field("watchdog_fired", exp.watchdog_fired, o_watchdog_fired);
                    check_field("off_button_used", exp.off_button_used, o_off_button_used);
                end
            end
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)
                || (i_cfg_valid && o_cfg_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("host_power_supervisor: mismatch");
                $finish;
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0) stall_left = pick_gap() + 1;
        end
    end

    // Every command, field extremes, off button, turn-on delay, schedule codes
    task automatic test_events();
        write_reg(hps_pkg::CFG_RUN_PIN, 16'd0);
        write_reg(hps_pkg::CFG_WDOG_MIN, 16'd0);
        write_reg(hps_pkg::CFG_LED_RED, 16'd255);
        write_reg(hps_pkg::CFG_LED_GREEN, 16'd0);
        write_reg(hps_pkg::CFG_LED_BLUE, 16'd255);
        send_item(hps_pkg::CMD_READ, 8'd0, 10'd0, 6'b000000);
        send_item(hps_pkg::CMD_OFF_BTN, 8'd0, 10'd1000, 6'b111111);
        send_item(hps_pkg::CMD_ON_BTN, 8'd255, 10'd1000, 6'b000000);
        send_item(hps_pkg::CMD_ON_BTN, 8'd0, 10'd0, 6'b001000);
        send_item(hps_pkg::CMD_OFF_BTN, 8'd0, 10'd0, 6'b001000);
        send_item(hps_pkg::CMD_OFF_BTN, 8'd0, 10'd0, 6'b000000);
        send_item(hps_pkg::CMD_RESET_BTN, 8'd0, 10'd0, 6'b001000);
        send_item(hps_pkg::CMD_RESET_BTN, 8'd0, 10'd0, 6'b000000);
        send_item(hps_pkg::CMD_RESET_BTN, 8'd0, 10'd0, 6'b000000);
        send_ticks(105, 10'd500, 6'b000000);
        send_item(hps_pkg::CMD_HOST_CMD, 8'd0, 10'd0, 6'b000000);
        send_item(hps_pkg::CMD_HOST_POLL, 8'd0, 10'd0, 6'b000000);
        send_item(hps_pkg::CMD_RTC_WAKE, 8'd0, 10'd0, 6'b000000);
        send_item(hps_pkg::CMD_SET_WAKE, 8'd100, 10'd0, 6'b000000);
        send_item(hps_pkg::CMD_SET_WAKE, 8'd101, 10'd0, 6'b000000);
        send_item(hps_pkg::CMD_SET_WAKE, 8'd128, 10'd0, 6'b000000);
        send_item(hps_pkg::CMD_SET_WAKE, 8'd255, 10'd0, 6'b000000);
        send_item(hps_pkg::CMD_SCHED_OFF, 8'd251, 10'd0, 6'b000000);
        send_item(hps_pkg::CMD_SCHED_OFF, 8'd250, 10'd0, 6'b000000);
        send_item(hps_pkg::CMD_SCHED_OFF, 8'd254, 10'd0, 6'b000000);
        send_item(hps_pkg::CMD_SCHED_OFF, 8'd255, 10'd0, 6'b000000);
        send_item(hps_pkg::CMD_SCHED_OFF, 8'd0, 10'd0, 6'b000000);
        send_ticks(2, 10'd0, 6'b000000);
        send_item(4'd10, 8'd0, 10'd0, 6'b000000);
        send_item(4'd15, 8'd255, 10'd1023, 6'b111111);
    endtask

    // Back-to-back ticks and events across colour bands and status bits
    task automatic test_back_to_back();
        calm = 1'b1;
        write_reg(hps_pkg::CFG_LED_GREEN, 16'd255);
        send_ticks(15, 10'd0, 6'b000100);
        send_ticks(15, 10'd151, 6'b000101);
        send_ticks(10, 10'd501, 6'b000011);
        send_item(hps_pkg::CMD_RESET_BTN, 8'd0, 10'd0, 6'b000000);
        send_item(hps_pkg::CMD_OFF_BTN, 8'd0, 10'd0, 6'b000000);
        send_item(hps_pkg::CMD_ON_BTN, 8'd0, 10'd0, 6'b000000);
        send_item(hps_pkg::CMD_SCHED_OFF, 8'd3, 10'd0, 6'b000000);
        send_ticks(5, 10'd1000, 6'b000000);
        calm = 1'b0;
    endtask

    // Scheduled off: countdown runs, is replaced, then a cancel
    task automatic test_sched_off();
        send_item(hps_pkg::CMD_RESET_BTN, 8'd0, 10'd0, 6'b000000);
        send_item(hps_pkg::CMD_SCHED_OFF, 8'd1, 10'd0, 6'b000000);
        send_ticks(40, 10'd300, 6'b000000);
        send_item(hps_pkg::CMD_SCHED_OFF, 8'd2, 10'd0, 6'b000000);
        send_ticks(20, 10'd300, 6'b000000);
        send_item(hps_pkg::CMD_SCHED_OFF, 8'd255, 10'd0, 6'b000000);
    endtask

    // Wake paths by power-on and by RUN pulse
    task automatic test_wake();
        send_item(hps_pkg::CMD_OFF_BTN, 8'd0, 10'd0, 6'b000000);
        send_item(hps_pkg::CMD_SET_WAKE, 8'd50, 10'd0, 6'b000000);
        send_ticks(5, 10'd600, 6'b110000);
        write_reg(hps_pkg::CFG_RUN_PIN, 16'd1);
        send_item(hps_pkg::CMD_RTC_WAKE, 8'd0, 10'd0, 6'b000000);
        send_item(hps_pkg::CMD_ON_BTN, 8'd0, 10'd0, 6'b000000);
        send_item(hps_pkg::CMD_RESET_BTN, 8'd0, 10'd0, 6'b001000);
        send_item(hps_pkg::CMD_ON_BTN, 8'd0, 10'd0, 6'b001000);
        send_item(hps_pkg::CMD_RESET_BTN, 8'd0, 10'd0, 6'b000000);
        send_item(hps_pkg::CMD_HOST_CMD, 8'd0, 10'd0, 6'b000000);
    endtask

    // Watchdog period writes, poll reload, largest period
    task automatic test_watchdog();
        write_reg(hps_pkg::CFG_WDOG_MIN, 16'd1);
        send_ticks(30, 10'd400, 6'b000000);
        send_item(hps_pkg::CMD_HOST_POLL, 8'd0, 10'd0, 6'b000000);
        send_ticks(30, 10'd400, 6'b001000);
        write_reg(hps_pkg::CFG_WDOG_MIN, 16'hFFFF);
        send_ticks(20, 10'd400, 6'b000000);
        send_item(hps_pkg::CMD_HOST_POLL, 8'd0, 10'd0, 6'b000000);
        write_reg(hps_pkg::CFG_RUN_PIN, 16'd0);
        write_reg(hps_pkg::CFG_WDOG_MIN, 16'd0);
    endtask

    // Random phases: tick bursts with random status, random events and codes
    task automatic test_random();
        int unsigned phase, k, n;
        logic [5:0] st;
        logic [9:0] soc;
        for (phase = 0; phase < 4; phase++) begin
            write_reg(hps_pkg::CFG_RUN_PIN, 16'($urandom_range(0, 1)));
            write_reg(hps_pkg::CFG_LED_RED, 16'($urandom_range(0, 255)));
            write_reg(hps_pkg::CFG_LED_GREEN, 16'($urandom_range(0, 255)));
            write_reg(hps_pkg::CFG_LED_BLUE, 16'($urandom_range(0, 255)));
            write_reg(hps_pkg::CFG_WDOG_MIN, 16'($urandom_range(0, 1)));
            for (k = 0; k < 15; k++) begin
                st = 6'($urandom());
                soc = ($urandom_range(0, 15) == 0) ? 10'($urandom()) : 10'($urandom_range(0, 1000));
                if (k == 7 && phase == 2) wait_drained();
                if ($urandom_range(0, 9) < 6) begin
                    n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
                    send_ticks(n, soc, st);
                end else begin
                    send_item(4'($urandom_range(1, 15)), 8'($urandom()), soc, st);
                end
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_cmd <= hps_pkg::CMD_TICK;
        i_arg <= '0;
        i_battery_soc <= '0;
        {i_input_present, i_battery_present, i_io5v_present,
         i_charging, i_charge_done, i_low_power} <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= hps_pkg::CFG_RUN_PIN;
        i_cfg_data <= '0;
        model_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_events();
        test_back_to_back();
        test_sched_off();
        test_wake();
        test_watchdog();
        test_random();
        wait_drained();
        if (errors == 0) begin
            $display("host_power_supervisor: match");
        end else begin
            $display("host_power_supervisor: mismatch");
        end
        $finish;
    end

    // Flag results that stay outstanding far beyond the pipeline depth
    always @(posedge i_clk) begin
        if (i_rst_n && errors == 0 && expected_results.size() > 64) begin
            errors++;
            $display("%0t: results overdue, expected %0d actual 0", $realtime,
                     expected_results.size());
        end
    end

endmodule
`default_nettype wire

/* files.f */
rtl/hps_pkg.sv
rtl/hps_front.sv
rtl/hps_queue.sv
rtl/hps_exec.sv
rtl/host_power_supervisor.sv
bench/tb.sv
